### hw/rtl/rmq_pkg.sv
// Shared types and constants for the rotation matrix to quaternion block.
package rmq_pkg;
   localparam int DATA_W = 16;
   localparam int LANES = 4;
   localparam int PAIR_W = 17;

   typedef logic signed [DATA_W-1:0] elem_type;

   typedef struct packed {
      elem_type m00;
      elem_type m01;
      elem_type m02;
      elem_type m10;
      elem_type m11;
      elem_type m12;
      elem_type m20;
      elem_type m21;
      elem_type m22;
   } req_type;

   typedef struct packed {
      elem_type   qx;
      elem_type   qy;
      elem_type   qz;
      elem_type   qw;
      logic [1:0] largest_component;
      logic       valid_res;
   } rsp_type;

   typedef enum logic [1:0] {
      COMP_X = 2'd0,
      COMP_Y = 2'd1,
      COMP_Z = 2'd2,
      COMP_W = 2'd3
   } comp_type;
endpackage

### hw/rtl/rmq_if.sv
// Valid/ready channel interface carrying one payload.
interface rmq_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/rmq_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module rmq_sqrt #(
   parameter int IN_W = 48,
   parameter int OUT_W = 24,
   parameter int TAG_W = 8
) (
   input  logic             clock,
   input  logic             en,
   input  logic [IN_W-1:0]  rad,
   input  logic [TAG_W-1:0] tag_in,
   output logic [OUT_W-1:0] root,
   output logic [TAG_W-1:0] tag_out
);
   logic [IN_W-1:0]  rem_ff [OUT_W+1];
   logic [OUT_W-1:0] res_ff [OUT_W+1];
   logic [TAG_W-1:0] tag_ff [OUT_W+1];

   assign rem_ff[0] = rad;
   assign res_ff[0] = '0;
   assign tag_ff[0] = tag_in;

   for (genvar k = 0; k < OUT_W; k++) begin : g_stage
      localparam int B = OUT_W - 1 - k;
      logic [IN_W+1:0] trial;
      logic [IN_W+1:0] rem_ext;
      logic [OUT_W-1:0] res_in;
      logic [IN_W-1:0]  rem_in;
      always_comb begin
         trial = ({2'b0, {(IN_W-OUT_W){1'b0}}, res_ff[k]} << (B + 1))
               + ({{(IN_W+1){1'b0}}, 1'b1} << (2 * B));
         rem_ext = {2'b0, rem_ff[k]};
         res_in = res_ff[k];
         rem_in = rem_ff[k];
         if (rem_ext >= trial) begin
            rem_in = IN_W'(rem_ext - trial);
            res_in[B] = 1'b1;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1] <= rem_in;
            res_ff[k+1] <= res_in;
            tag_ff[k+1] <= tag_ff[k];
         end
      end
   end

   assign root = res_ff[OUT_W];
   assign tag_out = tag_ff[OUT_W];
endmodule

### hw/rtl/rmq_div_lane.sv
// One divider lane: rounded P*2^(F-2)/V by restoring, one bit per stage; sign rides along.
module rmq_div_lane #(
   parameter int NUM_W = 32,
   parameter int DEN_W = 24
) (
   input  logic             clock,
   input  logic             en,
   input  logic [NUM_W-1:0] num,
   input  logic             neg,
   input  logic [DEN_W-1:0] den,
   output logic [NUM_W-1:0] quo,
   output logic             neg_out
);
   localparam int R_W = DEN_W + 2;
   logic [NUM_W-1:0] n_ff [NUM_W+1];
   logic [R_W-1:0]   r_ff [NUM_W+1];
   logic [DEN_W-1:0] d_ff [NUM_W+1];
   logic             s_ff [NUM_W+1];

   assign n_ff[0] = num;
   assign r_ff[0] = '0;
   assign d_ff[0] = den;
   assign s_ff[0] = neg;

   for (genvar k = 0; k < NUM_W; k++) begin : g_stage
      logic [R_W-1:0]   sh;
      logic [R_W-1:0]   r_in;
      logic [NUM_W-1:0] n_in;
      always_comb begin
         sh = {r_ff[k][R_W-2:0], n_ff[k][NUM_W-1]};
         n_in = {n_ff[k][NUM_W-2:0], 1'b0};
         r_in = sh;
         if (sh >= {2'b0, d_ff[k]}) begin
            r_in = sh - {2'b0, d_ff[k]};
            n_in[0] = 1'b1;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            n_ff[k+1] <= n_in;
            r_ff[k+1] <= r_in;
            d_ff[k+1] <= d_ff[k];
            s_ff[k+1] <= s_ff[k];
         end
      end
   end

   assign quo = n_ff[NUM_W];
   assign neg_out = s_ff[NUM_W];
endmodule

### hw/rtl/rotation_matrix_to_quaternion.sv
// Rotation matrix to quaternion converter, top level.
// Converts a 3x3 rotation matrix (signed, FRAC_BITS fraction bits) to a
// quaternion by Shepperd's method and takes one request per clock cycle
// while the output is not stalled. In order, a register holds the diagonal
// sums and selection, the square-root pipeline resolves the root bit by bit,
// a register sits ahead of the dividers, the four divider lanes resolve the
// quotients bit by bit, then the merge register; the divider lanes are the
// deepest part. A stalled output stops the whole pipeline, and the merge
// register stays loaded while the next request waits.
module rotation_matrix_to_quaternion #(
   parameter int FRAC_BITS = 14
) (
   input logic clock,
   input logic reset,
   rmq_if.sink   req,
   rmq_if.source rsp
);
   import rmq_pkg::*;

   localparam int SUM_W = (FRAC_BITS > 16) ? FRAC_BITS + 3 : 19;
   localparam int RAD_W = SUM_W + FRAC_BITS;
   localparam int ROOT_W = (RAD_W + 1) / 2;
   localparam int NUM_W = PAIR_W + FRAC_BITS;
   localparam int TAG_W = 2 + LANES * PAIR_W + LANES;
   localparam int SQ_LAT = ROOT_W;
   localparam int DV_LAT = NUM_W;
   localparam int LAT = 1 + SQ_LAT + 1 + DV_LAT + 1;
   localparam int LIM = (FRAC_BITS >= 15) ? 32767 : (1 << FRAC_BITS);

   logic adv;
   logic [LAT-2:0] vld_ff;
   logic rsp_valid_ff;
   rsp_type rsp_data_ff;

   assign adv = !rsp_valid_ff || rsp.ready;
   assign req.ready = adv && !reset;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= {vld_ff[LAT-3:0], req.valid};
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (adv) rsp_valid_ff <= vld_ff[LAT-2];
   end

   // stage 0: sums, selection, pairs
   logic signed [SUM_W-1:0] s [LANES];
   logic signed [PAIR_W-1:0] p [LANES];
   logic [1:0] big;
   logic signed [SUM_W-1:0] one;
   req_type r;
   logic signed [PAIR_W-1:0] a01, a02, a12, d12, d20, d01;

   always_comb begin
      r = req.data;
      one = SUM_W'(1) <<< FRAC_BITS;
      s[0] = one + SUM_W'(r.m00) - SUM_W'(r.m11) - SUM_W'(r.m22);
      s[1] = one - SUM_W'(r.m00) + SUM_W'(r.m11) - SUM_W'(r.m22);
      s[2] = one - SUM_W'(r.m00) - SUM_W'(r.m11) + SUM_W'(r.m22);
      s[3] = one + SUM_W'(r.m00) + SUM_W'(r.m11) + SUM_W'(r.m22);
      big = COMP_X;
      for (int i = 1; i < LANES; i++) if (s[i] > s[big]) big = 2'(i);
      a01 = PAIR_W'(r.m01) + PAIR_W'(r.m10);
      a02 = PAIR_W'(r.m02) + PAIR_W'(r.m20);
      a12 = PAIR_W'(r.m12) + PAIR_W'(r.m21);
      d12 = PAIR_W'(r.m12) - PAIR_W'(r.m21);
      d20 = PAIR_W'(r.m20) - PAIR_W'(r.m02);
      d01 = PAIR_W'(r.m01) - PAIR_W'(r.m10);
      p[0] = '0; p[1] = '0; p[2] = '0; p[3] = '0;
      unique case (big)
         COMP_X: begin p[1] = a01; p[2] = a02; p[3] = d12; end
         COMP_Y: begin p[0] = a01; p[2] = a12; p[3] = d20; end
         COMP_Z: begin p[0] = a02; p[1] = a12; p[3] = d01; end
         default: begin p[0] = d12; p[1] = d20; p[2] = d01; end
      endcase
   end

   logic [RAD_W-1:0] rad_ff;
   logic [TAG_W-1:0] tag_ff;
   logic [TAG_W-1:0] tag_in;
   logic [LANES-1:0] sgn;
   logic [LANES*PAIR_W-1:0] mags;
   logic [SUM_W-1:0] sbig;

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         sgn[i] = p[i][PAIR_W-1];
         mags[i*PAIR_W +: PAIR_W] = sgn[i] ? PAIR_W'(-p[i]) : p[i];
      end
      sbig = s[big];
      tag_in = {big, mags, sgn};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rad_ff <= sbig[SUM_W-1] ? '0 : (RAD_W'(sbig) << (FRAC_BITS - 2));
         tag_ff <= tag_in;
      end
   end

   // square root pipeline, held with the rest on a stall
   logic [ROOT_W-1:0] root;
   logic [TAG_W-1:0]  sq_tag;
   logic [ROOT_W-1:0] root_ff;
   logic [TAG_W-1:0]  sq_tag_ff;

   rmq_sqrt #(.IN_W(RAD_W), .OUT_W(ROOT_W), .TAG_W(TAG_W)) u_sqrt (
      .clock, .en(adv), .rad(rad_ff), .tag_in(tag_ff),
      .root, .tag_out(sq_tag)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         root_ff <= root;
         sq_tag_ff <= sq_tag;
      end
   end

   // divider lanes
   logic [NUM_W-1:0] quo [LANES];
   logic [LANES-1:0] qneg;
   logic [ROOT_W-1:0] den_out;
   logic [ROOT_W+1:0] side_ff [DV_LAT];
   logic [ROOT_W+1:0] side_out;
   logic [ROOT_W:0] den2;
   assign den2 = {root_ff, 1'b0};

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [NUM_W-1:0] num;
      logic [PAIR_W-1:0] mag;
      assign mag = sq_tag_ff[LANES + l*PAIR_W +: PAIR_W];
      assign num = (NUM_W'(mag) << (FRAC_BITS - 1)) + NUM_W'(root_ff);
      rmq_div_lane #(.NUM_W(NUM_W), .DEN_W(ROOT_W + 1)) u_div (
         .clock, .en(adv), .num, .neg(sq_tag_ff[l]), .den(den2),
         .quo(quo[l]), .neg_out(qneg[l])
      );
   end

   // largest index and root travel alongside the dividers
   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= {sq_tag_ff[TAG_W-1 -: 2], root_ff};
         for (int i = 1; i < DV_LAT; i++) side_ff[i] <= side_ff[i-1];
      end
   end
   assign side_out = side_ff[DV_LAT-1];
   assign den_out = side_out[ROOT_W-1:0];

   // merge
   function automatic elem_type sat_q(input logic [NUM_W-1:0] mag, input logic neg);
      elem_type v;
      v = (mag > NUM_W'(LIM)) ? DATA_W'(LIM) : DATA_W'(mag);
      return neg ? -v : v;
   endfunction

   rsp_type mrg;
   logic [1:0] bsel;
   elem_type q [LANES];
   always_comb begin
      bsel = side_out[ROOT_W +: 2];
      for (int i = 0; i < LANES; i++) begin
         q[i] = sat_q(quo[i], qneg[i]);
         if (bsel == 2'(i)) q[i] = sat_q(NUM_W'(den_out), 1'b0);
      end
      mrg.qx = q[0]; mrg.qy = q[1]; mrg.qz = q[2]; mrg.qw = q[3];
      mrg.largest_component = bsel;
      mrg.valid_res = 1'b1;
      if (den_out == '0) mrg = '0;
   end

   always_ff @(posedge clock) begin
      if (adv) rsp_data_ff <= mrg;
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
      else $error("response changed under stall");
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.data.qx <= LIM && rsp.data.qx >= -LIM
      && rsp.data.qw <= LIM && rsp.data.qw >= -LIM)
      else $error("component out of range");
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.data.valid_res |-> rsp.data.largest_component == COMP_X)
      else $error("invalid result with nonzero index");
endmodule
